// ===== hw/rtl/mmcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcrc_pkg
// Shared types, constants and byte-update functions of the multi-mode CRC.
// ----------------------------------------------------------------------------
package mmcrc_pkg;

  localparam int ModeW = 2;
  localparam int ByteW = 8;
  localparam int Crc16W = 16;
  localparam int Crc32W = 32;

  localparam logic [Crc16W-1:0] Poly16 = 16'h1021;
  localparam logic [Crc32W-1:0] Poly32 = 32'hEDB88320;
  localparam logic [ByteW-1:0] SwapIdxA = 8'hE6;
  localparam logic [ByteW-1:0] SwapIdxB = 8'hE7;
  localparam logic [Crc16W-1:0] SwapValA = 16'h8FD9;
  localparam logic [Crc16W-1:0] SwapValB = 16'h9FF8;
  localparam logic [Crc16W-1:0] Mask16 = 16'hFFFF;
  localparam logic [Crc32W-1:0] Mask32 = 32'hFFFFFFFF;

  typedef enum logic [ModeW-1:0] {
    MODE_CRC16_ZERO = 2'd0,
    MODE_CRC16_INV  = 2'd1,
    MODE_CTRL       = 2'd2,
    MODE_CRC32      = 2'd3
  } crc_mode_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             has_byte;
    logic             first_item;
    logic             last_item;
  } item_t;

  function automatic logic [Crc16W-1:0] crc16_msb_byte(
    input logic [Crc16W-1:0] r_in,
    input logic [ByteW-1:0]  b
  );
    logic [Crc16W-1:0] r;
    r = r_in ^ {b, 8'h00};
    for (int i = 0; i < ByteW; i++) begin
      if (r[Crc16W-1]) begin
        r = {r[Crc16W-2:0], 1'b0} ^ Poly16;
      end else begin
        r = {r[Crc16W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [Crc16W-1:0] crc16_ctrl_entry(input logic [ByteW-1:0] idx);
    logic [Crc16W-1:0] v;
    if (idx == SwapIdxA) begin
      v = SwapValA;
    end else if (idx == SwapIdxB) begin
      v = SwapValB;
    end else begin
      v = crc16_msb_byte('0, idx);
    end
    return v;
  endfunction

  function automatic logic [Crc16W-1:0] crc16_ctrl_byte(
    input logic [Crc16W-1:0] r,
    input logic [ByteW-1:0]  b
  );
    logic [ByteW-1:0] idx;
    idx = r[Crc16W-1:ByteW] ^ b;
    return {r[ByteW-1:0], 8'h00} ^ crc16_ctrl_entry(idx);
  endfunction

  function automatic logic [Crc32W-1:0] crc32_refl_byte(
    input logic [Crc32W-1:0] r_in,
    input logic [ByteW-1:0]  b
  );
    logic [Crc32W-1:0] r;
    r = r_in ^ {24'h000000, b};
    for (int i = 0; i < ByteW; i++) begin
      if (r[0]) begin
        r = {1'b0, r[Crc32W-1:1]} ^ Poly32;
      end else begin
        r = {1'b0, r[Crc32W-1:1]};
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mmcrc_update.sv =====
// ----------------------------------------------------------------------------
// mmcrc_update
// One-byte remainder update and final checksum for the selected CRC mode.
// ----------------------------------------------------------------------------
module mmcrc_update (
  input  mmcrc_pkg::crc_mode_t                 mode,
  input  mmcrc_pkg::item_t                     item,
  input  logic [mmcrc_pkg::Crc32W-1:0]         rem,
  output logic [mmcrc_pkg::Crc32W-1:0]         rem_next,
  output logic [mmcrc_pkg::Crc32W-1:0]         crc_out
);

  logic [mmcrc_pkg::Crc32W-1:0] start;
  logic [mmcrc_pkg::Crc32W-1:0] xorout;

  always_comb begin
    case (mode)
      mmcrc_pkg::MODE_CRC16_INV: begin
        start  = {16'h0000, mmcrc_pkg::Mask16};
        xorout = {16'h0000, mmcrc_pkg::Mask16};
      end
      mmcrc_pkg::MODE_CRC32: begin
        start  = mmcrc_pkg::Mask32;
        xorout = mmcrc_pkg::Mask32;
      end
      default: begin
        start  = '0;
        xorout = '0;
      end
    endcase
  end

  logic [mmcrc_pkg::Crc32W-1:0] base;
  assign base = item.first_item ? start : rem;

  always_comb begin
    rem_next = base;
    if (item.has_byte) begin
      case (mode)
        mmcrc_pkg::MODE_CRC32: begin
          rem_next = mmcrc_pkg::crc32_refl_byte(base, item.data_byte);
        end
        mmcrc_pkg::MODE_CTRL: begin
          rem_next = {16'h0000,
                      mmcrc_pkg::crc16_ctrl_byte(base[15:0], item.data_byte)};
        end
        default: begin
          rem_next = {16'h0000,
                      mmcrc_pkg::crc16_msb_byte(base[15:0], item.data_byte)};
        end
      endcase
    end
  end

  always_comb begin
    crc_out = rem_next ^ xorout;
    if (mode != mmcrc_pkg::MODE_CRC32) begin
      crc_out[31:16] = 16'h0000;
    end
  end

endmodule

// ===== hw/rtl/multi_mode_crc_engine.sv =====
// ----------------------------------------------------------------------------
// multi_mode_crc_engine
// Byte-stream CRC engine: CRC-16 (three variants) or reflected CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the 2-bit mode; it is
//   always ready and is to be written only while the engine is idle.
//   in channel (in_valid/in_ready) carries one request per message byte with
//   data_byte, has_byte, first_item and last_item. first_item restarts the
//   remainder from the mode's initial value; last_item emits the checksum.
//   A request with has_byte low and last_item high closes an empty message.
//   out channel (out_valid/out_ready) carries checksum and is_last; only a
//   request with last_item produces a result.
//   Throughput: one byte per cycle, except while a held result stalls a
//   last request; the byte update is one combinational eight-bit step
//   between the input register and the remainder/result registers. A last
//   request's checksum is registered as it leaves the input register.
//   Reset: mode 0, remainder 0, both pipeline registers empty.
//   Stall: when out_ready is low with a result held, a following last
//   request waits in the input register and in_ready drops; requests with
//   no result keep flowing.
// ----------------------------------------------------------------------------
module multi_mode_crc_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        first_item,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] checksum,
  output logic        is_last
);

  mmcrc_pkg::crc_mode_t             crc_mode;
  mmcrc_pkg::item_t                 item;
  logic                             item_valid;
  logic [mmcrc_pkg::Crc32W-1:0]     remainder;
  logic [mmcrc_pkg::Crc32W-1:0]     remainder_next;
  logic [mmcrc_pkg::Crc32W-1:0]     crc_out;
  logic                             item_adv;

  assign cfg_ready = 1'b1;
  assign is_last   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= mmcrc_pkg::MODE_CRC16_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      crc_mode <= mmcrc_pkg::crc_mode_t'(cfg_data);
    end
  end

  // advance the held request unless its result has nowhere to go
  assign item_adv = item_valid && (!item.last_item || !out_valid || out_ready);
  assign in_ready = !item_valid || item_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte  <= data_byte;
      item.has_byte   <= has_byte;
      item.first_item <= first_item;
      item.last_item  <= last_item;
    end
  end

  mmcrc_update u_update (
    .mode     (crc_mode),
    .item     (item),
    .rem      (remainder),
    .rem_next (remainder_next),
    .crc_out  (crc_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (item_adv) begin
      remainder <= remainder_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_adv && item.last_item) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_adv && item.last_item) begin
      checksum <= crc_out;
    end
  end

  a_last_loads_result: assert property (@(posedge clk) disable iff (rst)
    item_adv && item.last_item |=> out_valid && checksum == $past(crc_out))
    else $error("last request did not load the result register");

  a_held_item_stable: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_adv |=> item_valid && $stable(item))
    else $error("stalled request changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(item_adv && item.last_item && out_valid && !out_ready))
    else $error("result overwritten while stalled");

  a_remainder_hold: assert property (@(posedge clk) disable iff (rst)
    !item_adv |=> $stable(remainder))
    else $error("remainder changed without a request");

endmodule

// ===== tb/sv/multi_mode_crc_engine_tb.sv =====
// ----------------------------------------------------------------------------
// multi_mode_crc_engine_tb
// Self-checking bench for the multi-mode CRC engine. A local model of the four
// CRC variants predicts the checksum of every closed message. Directed tests
// cover the reset remainder, empty messages, field extremes, the controller
// table swaps and mode changes inside a message. Random phases then run
// well-formed messages with some noise, under random gaps on both channels.
// ----------------------------------------------------------------------------
module multi_mode_crc_engine_tb;

  typedef struct packed {
    logic [31:0] sum;
    logic        last;
  } crc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        has_byte = 1'b0;
  logic        first_item = 1'b0;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] checksum;
  logic        is_last;

  crc_result_t          expected_sums[$];
  crc_result_t          next_sum;
  mmcrc_pkg::crc_mode_t active_mode = mmcrc_pkg::MODE_CRC16_ZERO;
  logic [31:0]          model_remainder = '0;
  bit                   quiet = 1'b0;
  bit [3:0]             modes_seen = '0;
  int                   failures = 0;
  int                   requests_sent = 0;
  int                   results_seen = 0;

  multi_mode_crc_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .first_item(first_item),
    .last_item (last_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .checksum  (checksum),
    .is_last   (is_last)
  );

  always #5 clk = ~clk;

  function automatic bit take_gap();
    return !quiet && ($urandom_range(99) < 32);
  endfunction

  function automatic void flag_failure(string what);
    failures++;
    if (failures <= 10) begin
      $display("%s", what);
    end
  endfunction

  function automatic logic [15:0] fold_msb16(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] v;
    v = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      v = v[15] ? ({v[14:0], 1'b0} ^ 16'h1021) : {v[14:0], 1'b0};
    end
    return v;
  endfunction

  function automatic logic [15:0] fold_ctrl(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0]  idx;
    logic [15:0] entry;
    idx = acc[15:8] ^ b;
    if (idx == 8'hE6) begin
      entry = 16'h8FD9;
    end else if (idx == 8'hE7) begin
      entry = 16'h9FF8;
    end else begin
      entry = fold_msb16(16'h0000, idx);
    end
    return {acc[7:0], 8'h00} ^ entry;
  endfunction

  function automatic logic [31:0] fold_refl32(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] v;
    v = acc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ({1'b0, v[31:1]} ^ 32'hEDB88320) : {1'b0, v[31:1]};
    end
    return v;
  endfunction

  // initial value and final xor are the same word in every mode
  function automatic logic [31:0] mode_mask(input mmcrc_pkg::crc_mode_t m);
    case (m)
      mmcrc_pkg::MODE_CRC16_INV: return 32'h0000FFFF;
      mmcrc_pkg::MODE_CRC32:     return 32'hFFFFFFFF;
      default:                   return 32'h00000000;
    endcase
  endfunction

  function automatic void absorb_request(input logic [7:0] b, input logic h, input logic f,
                                         input logic l);
    logic [31:0] r;
    logic [31:0] s;
    r = model_remainder;
    if (f) begin
      r = mode_mask(active_mode);
    end
    if (h) begin
      case (active_mode)
        mmcrc_pkg::MODE_CRC32: r = fold_refl32(r, b);
        mmcrc_pkg::MODE_CTRL:  r = {16'h0000, fold_ctrl(r[15:0], b)};
        default:               r = {16'h0000, fold_msb16(r[15:0], b)};
      endcase
    end
    model_remainder = r;
    if (l) begin
      s = r ^ mode_mask(active_mode);
      if (active_mode != mmcrc_pkg::MODE_CRC32) begin
        s[31:16] = '0;
      end
      expected_sums.push_back(crc_result_t'{s, 1'b1});
    end
  endfunction

  task automatic send_request(input logic [7:0] b, input logic h, input logic f,
                              input logic l);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    has_byte   <= h;
    first_item <= f;
    last_item  <= l;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    absorb_request(b, h, f, l);
    requests_sent++;
  endtask

  // hold off until every checksum is back and the pipeline has emptied
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input mmcrc_pkg::crc_mode_t m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    active_mode = m;
    modes_seen[m] = 1'b1;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_sums.size() == 0) begin
        flag_failure($sformatf("unexpected result: checksum %08h is_last %b",
                               checksum, is_last));
      end else begin
        next_sum = expected_sums.pop_front();
        if (checksum !== next_sum.sum || is_last !== next_sum.last) begin
          flag_failure($sformatf("result %0d: expected %08h/%b, got %08h/%b", results_seen,
                                 next_sum.sum, next_sum.last, checksum, is_last));
        end
      end
    end
  end

  // remainder starts at zero after reset and carries on without first_item
  task automatic test_reset_state();
    send_request(8'hA5, 1'b1, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0, 1'b1);
    send_request(8'h3C, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_empty_messages();
    for (int m = 0; m < 4; m++) begin
      write_mode(mmcrc_pkg::crc_mode_t'(m));
      send_request(8'h5A, 1'b0, 1'b1, 1'b1);
    end
  endtask

  task automatic test_field_extremes();
    write_mode(mmcrc_pkg::MODE_CTRL);
    send_request(8'hE6, 1'b1, 1'b1, 1'b1);
    send_request(8'hE7, 1'b1, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0, 1'b1);
    write_mode(mmcrc_pkg::MODE_CRC32);
    send_request(8'hFF, 1'b1, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0, 1'b1);
    write_mode(mmcrc_pkg::MODE_CRC16_INV);
    send_request(8'h00, 1'b1, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_mode_switch();
    write_mode(mmcrc_pkg::MODE_CRC32);
    send_request(8'h81, 1'b1, 1'b1, 1'b0);
    write_mode(mmcrc_pkg::MODE_CRC16_INV);
    send_request(8'h7E, 1'b1, 1'b0, 1'b1);
    write_mode(mmcrc_pkg::MODE_CTRL);
    send_request(8'hC3, 1'b1, 1'b1, 1'b0);
    write_mode(mmcrc_pkg::MODE_CRC32);
    send_request(8'h18, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic();
    int                   phase_items;
    int                   len;
    mmcrc_pkg::crc_mode_t m;
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        m = mmcrc_pkg::crc_mode_t'(p);
      end else if (p == 11) begin
        m = mmcrc_pkg::MODE_CRC32;
      end else begin
        m = mmcrc_pkg::crc_mode_t'($urandom_range(3));
      end
      write_mode(m);
      quiet = (p == 5);
      phase_items = 0;
      while (phase_items < 125) begin
        if ($urandom_range(99) < 8) begin
          send_request(8'($urandom_range(255)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
          phase_items++;
        end else begin
          len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(1, 8);
          for (int i = 0; i < len; i++) begin
            send_request(8'($urandom_range(255)), ($urandom_range(19) != 0), (i == 0),
                         (i == len - 1));
          end
          phase_items += len;
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_empty_messages();
    test_field_extremes();
    test_mode_switch();
    test_random_traffic();
    in_valid <= 1'b0;
    guard = 0;
    while (expected_sums.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (expected_sums.size() != 0) begin
      flag_failure($sformatf("%0d checksums never arrived", expected_sums.size()));
    end
    $display("Sent %0d requests, checked %0d checksums, modes exercised %b, %0d failures",
             requests_sent, results_seen, modes_seen, failures);
    $display("Covered empty and unseeded messages, table swaps and mid-message mode changes");
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout: %0d checksums still outstanding", expected_sums.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mmcrc_pkg.sv
hw/rtl/mmcrc_update.sv
hw/rtl/multi_mode_crc_engine.sv
tb/sv/multi_mode_crc_engine_tb.sv
